/* sv/ngcm_pkg.sv */
// ----------------------------------------------------------------------------
// ngcm_pkg
// Shared types, constants and scoring helper for the glyph cell matcher.
// ----------------------------------------------------------------------------
package ngcm_pkg;

  localparam int CELL_ROWS  = 16;
  localparam int ROW_W      = 8;
  localparam int HALF_ROWS  = CELL_ROWS / 2;
  localparam int WORD_W     = HALF_ROWS * ROW_W;
  localparam int CHAR_W     = 8;
  localparam int HALF_SUM_W = 11;
  localparam int SCORE_W    = 12;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [1:0] {
    CMD_LOAD_GLYPH = 2'd0,
    CMD_LOAD_LIST  = 2'd1,
    CMD_MATCH      = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_reg_t;

  // Sum of the eight row bytes of img XOR gly, taken as integers.
  function automatic logic [HALF_SUM_W-1:0] half_sum(input logic [WORD_W-1:0] img,
                                                     input logic [WORD_W-1:0] gly);
    logic [HALF_SUM_W-1:0] acc;
    logic [WORD_W-1:0]     x;
    acc = '0;
    x   = img ^ gly;
    for (int k = 0; k < HALF_ROWS; k++) begin
      acc = acc + HALF_SUM_W'(x[k*ROW_W +: ROW_W]);
    end
    return acc;
  endfunction

endpackage

/* sv/ngcm_ram.sv */
// ----------------------------------------------------------------------------
// ngcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ngcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/nearest_glyph_cell_match.sv */
// Match of N candidates: S_LO, S_HI per candidate, then S_DRAIN1, S_DRAIN2, S_DONE,
// which registers the result. Loads keep S_IDLE; a new command is taken the cycle
// after. Commands are taken only in S_IDLE; S_DONE waits while the result is held;
// the single glyph RAM read port fetches two 64-bit halves per candidate.
// Reset (rst_n, synchronous): clears control and config registers
// (invert 0, count 1); glyph and list RAMs are not cleared.
// ----------------------------------------------------------------------------
// nearest_glyph_cell_match
// Scores a 16-row one-bit cell against each listed glyph and returns the
// first candidate with the smallest byte-sum XOR score.
// ----------------------------------------------------------------------------
module nearest_glyph_cell_match #(
  parameter int GLYPH_COUNT = 256,
  parameter int LIST_DEPTH  = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config
  input  logic                                 cfg_we,
  input  logic [ngcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ngcm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_command,
  input  logic [7:0]                           in_glyph_code,
  input  logic                                 in_glyph_half,
  input  logic [63:0]                          in_glyph_word,
  input  logic [7:0]                           in_list_index,
  input  logic [7:0]                           in_list_char,
  input  logic [63:0]                          in_cell_rows_low,
  input  logic [63:0]                          in_cell_rows_high,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_best_char,
  output logic [11:0]                          out_best_score
);

  localparam int CODE_W = $clog2(GLYPH_COUNT);
  localparam int GA_W   = $clog2(2 * GLYPH_COUNT);
  localparam int IDX_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int WORD_W = ngcm_pkg::WORD_W;
  localparam int CHAR_W = ngcm_pkg::CHAR_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LO     = 6'b000010,
    S_HI     = 6'b000100,
    S_DRAIN1 = 6'b001000,
    S_DRAIN2 = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_eff;
  logic [9:0]       cnt_ext;

  logic                            cfg_invert_r;
  logic [ngcm_pkg::CFG_DATA_W-1:0] cfg_count_r;

  logic [WORD_W-1:0] img_lo_r, img_hi_r;
  logic [CHAR_W-1:0] char_a_r, char_b_r, char_c_r;
  logic              oob_a_r, oob_b_r;
  logic              hi_v_r, sc_v_r, first_r;
  logic [ngcm_pkg::HALF_SUM_W-1:0] lo_sum_r;
  logic [ngcm_pkg::SCORE_W-1:0]    score_r, best_score_r;
  logic [CHAR_W-1:0]               best_char_r;

  logic                    out_valid_r;
  logic [CHAR_W-1:0]       out_char_r;
  logic [ngcm_pkg::SCORE_W-1:0] out_score_r;

  logic in_acc, match_go, last, done_fire;

  // RAM ports
  logic              g_we, g_re;
  logic [GA_W-1:0]   g_waddr, g_raddr;
  logic [WORD_W-1:0] g_rdata, g_data;
  logic              l_we, l_re;
  logic [IDX_W-1:0]  l_waddr, l_raddr;
  logic [CHAR_W-1:0] l_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign cnt_ext  = {1'b0, cfg_count_r};
  assign cnt_eff  = (cnt_ext > 10'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : CNT_W'(cnt_ext);
  assign match_go = in_acc && (in_command == ngcm_pkg::CMD_MATCH) && (cnt_eff != '0);
  assign last     = ((idx_r + CNT_W'(1)) == cnt_r);
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // loads
  assign g_we    = in_acc && (in_command == ngcm_pkg::CMD_LOAD_GLYPH) &&
                   ({1'b0, in_glyph_code} < 9'(GLYPH_COUNT));
  assign g_waddr = {in_glyph_code[CODE_W-1:0], in_glyph_half};
  assign l_we    = in_acc && (in_command == ngcm_pkg::CMD_LOAD_LIST) &&
                   ({2'b00, in_list_index} < 10'(LIST_DEPTH));
  assign l_waddr = IDX_W'(in_list_index);

  ngcm_ram #(.WIDTH(WORD_W), .DEPTH(2 * GLYPH_COUNT)) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (in_glyph_word),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  ngcm_ram #(.WIDTH(CHAR_W), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (in_list_char),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // Sequencer: S_LO fetches the low half and prefetches the next list entry,
  // S_HI the high half. Low-half sum registers in S_HI, the full score on hi_v_r.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    l_re      = 1'b0;
    l_raddr   = idx_r[IDX_W-1:0];
    g_re      = 1'b0;
    g_raddr   = {char_a_r[CODE_W-1:0], 1'b1};
    case (state_r)
      S_IDLE: begin
        if (match_go) begin
          state_nxt = S_LO;
          idx_nxt   = '0;
          l_re      = 1'b1;
          l_raddr   = '0;
        end
      end
      S_LO: begin
        g_re      = 1'b1;
        g_raddr   = {l_rdata[CODE_W-1:0], 1'b0};
        l_re      = !last;
        l_raddr   = IDX_W'(idx_r + CNT_W'(1));
        state_nxt = S_HI;
      end
      S_HI: begin
        g_re = 1'b1;
        if (last) begin
          state_nxt = S_DRAIN1;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_LO;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_DONE;
      S_DONE: begin
        if (done_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // out-of-range codes score against blank rows
  always_comb begin
    g_data = g_rdata;
    if ((state_r == S_HI && oob_a_r) || (hi_v_r && oob_b_r)) begin
      g_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      cfg_invert_r <= 1'b0;
      cfg_count_r  <= ngcm_pkg::CFG_DATA_W'(1);
      hi_v_r       <= 1'b0;
      sc_v_r       <= 1'b0;
      first_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      hi_v_r  <= (state_r == S_HI);
      sc_v_r  <= hi_v_r;
      if (cfg_we) begin
        case (cfg_index)
          ngcm_pkg::CFG_INVERT: cfg_invert_r <= cfg_wdata[0];
          ngcm_pkg::CFG_COUNT:  cfg_count_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (match_go) begin
        first_r <= 1'b1;
      end else if (sc_v_r) begin
        first_r <= 1'b0;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (match_go) begin
      img_lo_r <= cfg_invert_r ? ~in_cell_rows_low  : in_cell_rows_low;
      img_hi_r <= cfg_invert_r ? ~in_cell_rows_high : in_cell_rows_high;
      cnt_r    <= cnt_eff;
    end
    if (state_r == S_LO) begin
      char_a_r <= l_rdata;
      oob_a_r  <= ({1'b0, l_rdata} >= 9'(GLYPH_COUNT));
    end
    if (state_r == S_HI) begin
      lo_sum_r <= ngcm_pkg::half_sum(img_lo_r, g_data);
      char_b_r <= char_a_r;
      oob_b_r  <= oob_a_r;
    end
    if (hi_v_r) begin
      score_r  <= ngcm_pkg::SCORE_W'(lo_sum_r) +
                  ngcm_pkg::SCORE_W'(ngcm_pkg::half_sum(img_hi_r, g_data));
      char_c_r <= char_b_r;
    end
    // strict less-than keeps the earliest of equal scores
    if (sc_v_r && (first_r || score_r < best_score_r)) begin
      best_score_r <= score_r;
      best_char_r  <= char_c_r;
    end
    if (done_fire) begin
      out_char_r  <= best_char_r;
      out_score_r <= best_score_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_char  = out_char_r;
  assign out_best_score = out_score_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LO || state_r == S_HI) |-> (idx_r < cnt_r))
    else $error("candidate index past count");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(g_re && g_we) && !(l_re && l_we))
    else $error("RAM load during match");

  a_score_follows_hi: assert property (@(posedge clk) disable iff (!rst_n)
    sc_v_r |-> $past(state_r == S_HI, 2))
    else $error("score stage without high-half fetch");

  a_best_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !first_r)
    else $error("match finished with no candidate scored");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word raised outside done state");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives glyph loads, candidate list loads and cell matches into the glyph
// cell matcher, predicts each best candidate and score from a local copy of
// the glyph store and list, and checks every result word in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int GLYPHS        = 256;
  localparam int LIST_LEN      = 256;
  localparam int RANDOM_WORDS  = 1170;
  localparam int SETTLE_CYCLES = 2 * LIST_LEN + 16;
  localparam int HOLD_CYCLES   = 1500;
  localparam int LIMIT         = 4000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  code;
    logic        half;
    logic [63:0] gword;
    logic [7:0]  lidx;
    logic [7:0]  lchar;
    logic [63:0] lo;
    logic [63:0] hi;
  } cell_cmd_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [11:0] score;
  } match_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  ngcm_pkg::cfg_reg_t cfg_index = ngcm_pkg::CFG_INVERT;
  logic [ngcm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [7:0]  in_glyph_code = '0;
  logic        in_glyph_half = 1'b0;
  logic [63:0] in_glyph_word = '0;
  logic [7:0]  in_list_index = '0;
  logic [7:0]  in_list_char = '0;
  logic [63:0] in_cell_rows_low = '0;
  logic [63:0] in_cell_rows_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  out_best_char;
  logic [11:0] out_best_score;

  nearest_glyph_cell_match dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_glyph_code    (in_glyph_code),
    .in_glyph_half    (in_glyph_half),
    .in_glyph_word    (in_glyph_word),
    .in_list_index    (in_list_index),
    .in_list_char     (in_list_char),
    .in_cell_rows_low (in_cell_rows_low),
    .in_cell_rows_high(in_cell_rows_high),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_best_char    (out_best_char),
    .out_best_score   (out_best_score)
  );

  // commands waiting for the driver, best matches waiting for the dut
  cell_cmd_t     pending_cmds[$];
  match_result_t expected_matches[$];

  // predictor copy of the block state
  logic [63:0] model_glyph [0:2*GLYPHS-1];
  logic [7:0]  model_list  [0:LIST_LEN-1];
  logic        model_invert;
  logic [8:0]  model_count;

  // stimulus-side view, used to keep matches off unwritten entries
  logic [63:0] gen_glyph    [0:2*GLYPHS-1];
  bit          gen_glyph_ok [0:2*GLYPHS-1];
  logic [7:0]  gen_list     [0:LIST_LEN-1];
  bit          gen_list_ok  [0:LIST_LEN-1];
  bit          in_pool      [0:GLYPHS-1];
  int          glyph_pool[$];
  logic        gen_invert;
  int          words_made;

  bit idle_on = 1'b1;
  int holds_wanted;
  int holds_given;
  int hold_left;
  int stall_left;
  int gap_left;
  int cycles;
  int mismatches;
  int matches_checked;
  int glyph_loads;
  int list_loads;
  int unused_words;
  int words_taken;
  int settings_done;
  cell_cmd_t tx_word;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic logic [11:0] cell_score(input logic [7:0] ch, input logic [63:0] lo,
                                             input logic [63:0] hi);
    logic [11:0] sum;
    logic [7:0]  img;
    logic [7:0]  gly;
    logic [63:0] g_lo;
    logic [63:0] g_hi;
    sum  = '0;
    g_lo = model_glyph[{ch, 1'b0}];
    g_hi = model_glyph[{ch, 1'b1}];
    for (int k = 0; k < 16; k++) begin
      img = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
      gly = (k < 8) ? g_lo[8*k +: 8] : g_hi[8*(k-8) +: 8];
      if (model_invert) img = ~img;
      sum = sum + 12'(img ^ gly);
    end
    return sum;
  endfunction

  // update the local state for one accepted word; a match queues its best candidate
  function automatic void apply_word(input cell_cmd_t w);
    int            n;
    logic [11:0]   s;
    match_result_t best;
    words_taken++;
    case (w.cmd)
      ngcm_pkg::CMD_LOAD_GLYPH: begin
        model_glyph[{w.code, w.half}] = w.gword;
        glyph_loads++;
      end
      ngcm_pkg::CMD_LOAD_LIST: begin
        model_list[w.lidx] = w.lchar;
        list_loads++;
      end
      ngcm_pkg::CMD_MATCH: begin
        n = (model_count > LIST_LEN) ? LIST_LEN : int'(model_count);
        if (n != 0) begin
          best.ch    = model_list[0];
          best.score = cell_score(model_list[0], w.lo, w.hi);
          for (int i = 1; i < n; i++) begin
            s = cell_score(model_list[i], w.lo, w.hi);
            if (s < best.score) begin
              best.score = s;
              best.ch    = model_list[i];
            end
          end
          expected_matches.push_back(best);
        end
      end
      default: unused_words++;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && in_stall) begin
      // stalled word stays put
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() != 0) begin
      tx_word = pending_cmds.pop_front();
      in_command        <= tx_word.cmd;
      in_glyph_code     <= tx_word.code;
      in_glyph_half     <= tx_word.half;
      in_glyph_word     <= tx_word.gword;
      in_list_index     <= tx_word.lidx;
      in_list_char      <= tx_word.lchar;
      in_cell_rows_low  <= tx_word.lo;
      in_cell_rows_high <= tx_word.hi;
      in_valid <= 1'b1;
      gap_left <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (holds_given < holds_wanted) begin
      holds_given <= holds_given + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_stall  <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_cmd_t     seen;
    match_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.cmd   = in_command;
        seen.code  = in_glyph_code;
        seen.half  = in_glyph_half;
        seen.gword = in_glyph_word;
        seen.lidx  = in_list_index;
        seen.lchar = in_list_char;
        seen.lo    = in_cell_rows_low;
        seen.hi    = in_cell_rows_high;
        apply_word(seen);
      end
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("result with none pending: char %0d score %0d",
                                    out_best_char, out_best_score));
        end else begin
          want = expected_matches.pop_front();
          matches_checked++;
          if (out_best_char !== want.ch)
            report_mismatch($sformatf("best_char %0d, expected %0d", out_best_char, want.ch));
          if (out_best_score !== want.score)
            report_mismatch($sformatf("best_score %0d, expected %0d (char %0d)",
                                      out_best_score, want.score, want.ch));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               expected_matches.size());
      $display("[nearest_glyph_cell_match] ERROR");
      $finish;
    end
  end

  function automatic cell_cmd_t noise_word(input logic [1:0] cmd);
    cell_cmd_t w;
    w.cmd   = cmd;
    w.code  = 8'($urandom);
    w.half  = 1'($urandom);
    w.gword = {$urandom, $urandom};
    w.lidx  = 8'($urandom);
    w.lchar = 8'($urandom);
    w.lo    = {$urandom, $urandom};
    w.hi    = {$urandom, $urandom};
    return w;
  endfunction

  task automatic queue_word(input cell_cmd_t w);
    if (w.cmd == ngcm_pkg::CMD_LOAD_GLYPH) begin
      gen_glyph[{w.code, w.half}]    = w.gword;
      gen_glyph_ok[{w.code, w.half}] = 1'b1;
      if (gen_glyph_ok[{w.code, 1'b0}] && gen_glyph_ok[{w.code, 1'b1}] && !in_pool[w.code]) begin
        in_pool[w.code] = 1'b1;
        glyph_pool.push_back(int'(w.code));
      end
    end else if (w.cmd == ngcm_pkg::CMD_LOAD_LIST) begin
      gen_list[w.lidx]    = w.lchar;
      gen_list_ok[w.lidx] = 1'b1;
    end
    words_made++;
    pending_cmds.push_back(w);
  endtask

  task automatic load_glyph(input logic [7:0] code, input logic half, input logic [63:0] v);
    cell_cmd_t w;
    w       = noise_word(ngcm_pkg::CMD_LOAD_GLYPH);
    w.code  = code;
    w.half  = half;
    w.gword = v;
    queue_word(w);
  endtask

  task automatic load_list(input logic [7:0] idx, input logic [7:0] ch);
    cell_cmd_t w;
    w       = noise_word(ngcm_pkg::CMD_LOAD_LIST);
    w.lidx  = idx;
    w.lchar = ch;
    queue_word(w);
  endtask

  task automatic match_cell(input logic [63:0] lo, input logic [63:0] hi);
    cell_cmd_t w;
    w    = noise_word(ngcm_pkg::CMD_MATCH);
    w.lo = lo;
    w.hi = hi;
    queue_word(w);
  endtask

  function automatic logic [7:0] pool_or_any();
    if (glyph_pool.size() != 0 && $urandom_range(0, 4) != 0)
      return 8'(glyph_pool[$urandom_range(0, glyph_pool.size() - 1)]);
    return 8'($urandom);
  endfunction

  // every list entry a match reads, and both halves of its glyph, must be written first
  task automatic ready_for_match(input int n);
    for (int i = 0; i < n; i++) begin
      if (!gen_list_ok[i]) load_list(8'(i), pool_or_any());
      for (int h = 0; h < 2; h++) begin
        if (!gen_glyph_ok[{gen_list[i], h[0]}])
          load_glyph(gen_list[i], h[0], {$urandom, $urandom});
      end
    end
  endtask

  task automatic add_random_word(input int n);
    int          r;
    int          c;
    logic        h;
    logic [63:0] mask;
    logic [63:0] v;
    r    = $urandom_range(0, 99);
    mask = gen_invert ? '1 : '0;
    if (r < 40) begin
      ready_for_match(n);
      r = $urandom_range(0, 9);
      if (n > 0 && r < 3) begin
        // cell equal to one candidate, sometimes one bit off
        c = int'(gen_list[$urandom_range(0, n - 1)]);
        v = (r == 0) ? (64'd1 << $urandom_range(0, 63)) : 64'd0;
        match_cell(gen_glyph[{8'(c), 1'b0}] ^ mask ^ v, gen_glyph[{8'(c), 1'b1}] ^ mask);
      end else if (r == 3) begin
        match_cell('0, '0);
      end else if (r == 4) begin
        match_cell('1, '1);
      end else begin
        match_cell({$urandom, $urandom}, {$urandom, $urandom});
      end
    end else if (r < 65) begin
      if (n > 0 && $urandom_range(0, 1) == 0) c = int'(gen_list[$urandom_range(0, n - 1)]);
      else c = $urandom_range(0, GLYPHS - 1);
      h = 1'($urandom);
      r = $urandom_range(0, 9);
      if (r < 2 && glyph_pool.size() != 0)
        v = gen_glyph[{8'(glyph_pool[$urandom_range(0, glyph_pool.size() - 1)]), 1'($urandom)}];
      else if (r == 2) v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      else v = {$urandom, $urandom};
      load_glyph(8'(c), h, v);
    end else if (r < 92) begin
      if (n > 0 && $urandom_range(0, 9) < 7) c = $urandom_range(0, n - 1);
      else c = $urandom_range(0, LIST_LEN - 1);
      load_list(8'(c), pool_or_any());
    end else begin
      queue_word(noise_word(CMD_UNUSED));
    end
  endtask

  task automatic set_config(input logic inv, input logic [8:0] cnt);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ngcm_pkg::CFG_INVERT;
    cfg_wdata <= ngcm_pkg::CFG_DATA_W'(inv);
    @(posedge clk);
    cfg_index <= ngcm_pkg::CFG_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_invert = inv;
    model_count  = cnt;
    gen_invert   = inv;
    settings_done++;
  endtask

  // everything sent and answered, then room for a match that returns nothing
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          goal;
    int          stop;
    int          eff;
    logic        inv;
    logic [8:0]  cnt;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_config(1'b0, 9'd1);

    // directed: extreme rows, every command, ties, count zero and the unused command
    load_glyph(8'd0, 1'b0, '0);
    load_glyph(8'd0, 1'b1, '0);
    load_glyph(8'd255, 1'b0, '1);
    load_glyph(8'd255, 1'b1, '1);
    load_list(8'd0, 8'd255);
    match_cell('0, '0);
    match_cell('1, '1);
    queue_word(noise_word(CMD_UNUSED));
    load_list(8'd255, 8'd0);
    load_list(8'd1, 8'd0);
    load_glyph(8'd7, 1'b0, '0);
    load_glyph(8'd7, 1'b1, '0);
    load_list(8'd2, 8'd7);
    wait_idle();
    set_config(1'b1, 9'd3);
    match_cell('1, '1);
    match_cell({8{8'h0f}}, {8{8'h0f}});
    match_cell({$urandom, $urandom}, {$urandom, $urandom});
    wait_idle();
    set_config(1'b0, 9'd0);
    match_cell({$urandom, $urandom}, {$urandom, $urandom});
    match_cell('1, '0);
    wait_idle();

    goal  = words_made + RANDOM_WORDS;
    phase = 0;
    while (words_made < goal) begin
      inv = 1'($urandom);
      case (phase % 6)
        2:       cnt = 9'd256;
        4:       cnt = 9'd511;
        default: cnt = ($urandom_range(0, 3) != 0) ? 9'($urandom_range(1, 8))
                                                   : 9'($urandom_range(9, 40));
      endcase
      idle_on = (phase % 3 != 1);
      set_config(inv, cnt);
      eff = (cnt > LIST_LEN) ? LIST_LEN : int'(cnt);
      ready_for_match(eff);
      stop = words_made + ((eff > 40) ? 40 : 150);
      if (stop > goal) stop = goal;
      if (phase == 1 || phase == 3) holds_wanted++;
      while (words_made < stop) add_random_word(eff);
      wait_idle();
      phase++;
    end

    if (expected_matches.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_matches.size()));
    $display("run: %0d words taken (%0d glyph loads, %0d list loads, %0d unused),",
             words_taken, glyph_loads, list_loads, unused_words);
    $display("run: %0d matches checked, %0d register settings over both invert values, %s",
             matches_checked, settings_done, "counts 0, 1, small, 256, 511");
    if (mismatches == 0) begin
      $display("[nearest_glyph_cell_match] OK");
    end else begin
      $display("[nearest_glyph_cell_match] ERROR");
    end
    $finish;
  end

endmodule
